// ===== rtl/bmad_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bmad_pkg;

	// Access kinds carried with each request
	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_PEEK  = 2'd2,
		ACT_PEEK3 = 2'd3
	} action_t;

	// Target selects
	typedef enum logic [3:0] {
		TGT_SYSRAM  = 4'd0,
		TGT_BANKRAM = 4'd1,
		TGT_ROM     = 4'd2,
		TGT_CART    = 4'd3,
		TGT_VIA1    = 4'd4,
		TGT_VIA2    = 4'd5,
		TGT_VIDEO   = 4'd6,
		TGT_SOUND   = 4'd7,
		TGT_EMU     = 4'd8,
		TGT_MIDI    = 4'd9,
		TGT_UART1   = 4'd10,
		TGT_UART2   = 4'd11,
		TGT_NONE    = 4'd12
	} target_t;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_GEN2_MODE    = 3'd0,
		CFG_SYS_BANKS    = 3'd1,
		CFG_BRAM_COUNT   = 3'd2,
		CFG_DEV_ENABLES  = 3'd3,
		CFG_MIDI_BASE    = 3'd4,
		CFG_UART1_BASE   = 3'd5,
		CFG_UART2_BASE   = 3'd6,
		CFG_UNUSED       = 3'd7
	} cfg_index_t;

	// Device enable bits
	localparam int DEV_VIA2  = 0;
	localparam int DEV_MIDI  = 1;
	localparam int DEV_UART1 = 2;
	localparam int DEV_UART2 = 3;
	localparam int DEV_CART  = 4;

	// Address map
	localparam logic [15:0] ADDR_IO_BASE    = 16'h9F00;
	localparam logic [15:0] ADDR_VIA2_BASE  = 16'h9F10;
	localparam logic [15:0] ADDR_VIDEO_BASE = 16'h9F20;
	localparam logic [15:0] ADDR_SOUND_BASE = 16'h9F40;
	localparam logic [15:0] ADDR_SOUND_END  = 16'h9F60;
	localparam logic [15:0] ADDR_SLOW_BASE  = 16'h9FA0;
	localparam logic [15:0] ADDR_EMU_BASE   = 16'h9FB0;
	localparam logic [15:0] ADDR_EMU_END    = 16'h9FC0;
	localparam logic [15:0] ADDR_BRAM_BASE  = 16'hA000;
	localparam logic [15:0] ADDR_ROM_BASE   = 16'hC000;
	localparam logic [15:0] MIDI_MASK       = 16'hFFF0;
	localparam logic [7:0]  IO_OPEN_BUS     = 8'h9F;
	localparam logic [1:0]  SLOW_WAITS      = 2'd3;

	// Configuration reset values
	localparam logic [8:0]  RST_SYS_BANKS  = 9'd1;
	localparam logic [8:0]  RST_BRAM_COUNT = 9'd64;
	localparam logic [15:0] RST_MIDI_BASE  = 16'h9F60;
	localparam logic [15:0] RST_UART1_BASE = 16'h9FC0;
	localparam logic [15:0] RST_UART2_BASE = 16'h9FC8;

	localparam int CFG_DATA_W  = 16;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 48;

	typedef struct packed {
		logic        gen2_mode;
		logic [8:0]  system_bank_count;
		logic [8:0]  banked_ram_count;
		logic [4:0]  device_enables;
		logic [15:0] midi_base;
		logic [15:0] uart1_base;
		logic [15:0] uart2_base;
	} cfg_t;

	typedef struct packed {
		action_t            action;
		logic [15:0]        address;
		logic [7:0]         cpu_bank;
		logic [7:0]         write_data;
		logic signed [8:0]  bank_override;
	} access_t;

	typedef struct packed {
		target_t     target;
		logic [23:0] physical_address;
		logic [4:0]  register_offset;
		logic [7:0]  open_bus_data;
		logic [1:0]  wait_cycles;
		logic        write_strobe;
	} result_t;

	// Bank register update request from the decoder
	typedef struct packed {
		logic       ram_we;
		logic       rom_we;
		logic [7:0] data;
	} bank_wr_t;

endpackage

`default_nettype wire

// ===== rtl/bmad_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmad_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire bmad_pkg::cfg_index_t           cfg_index,
	input  wire logic [bmad_pkg::CFG_DATA_W-1:0] cfg_data,
	output bmad_pkg::cfg_t                      cfg
);
	import bmad_pkg::*;

	cfg_t cfg_q;

	// Register file, written by index; unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gen2_mode         <= 1'b0;
			cfg_q.system_bank_count <= RST_SYS_BANKS;
			cfg_q.banked_ram_count  <= RST_BRAM_COUNT;
			cfg_q.device_enables    <= 5'd0;
			cfg_q.midi_base         <= RST_MIDI_BASE;
			cfg_q.uart1_base        <= RST_UART1_BASE;
			cfg_q.uart2_base        <= RST_UART2_BASE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GEN2_MODE:   cfg_q.gen2_mode         <= cfg_data[0];
				CFG_SYS_BANKS:   cfg_q.system_bank_count <= cfg_data[8:0];
				CFG_BRAM_COUNT:  cfg_q.banked_ram_count  <= cfg_data[8:0];
				CFG_DEV_ENABLES: cfg_q.device_enables    <= cfg_data[4:0];
				CFG_MIDI_BASE:   cfg_q.midi_base         <= cfg_data;
				CFG_UART1_BASE:  cfg_q.uart1_base        <= cfg_data;
				CFG_UART2_BASE:  cfg_q.uart2_base        <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/bmad_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bmad_decode #(
	parameter int BUILTIN_ROM_BANKS = 32
) (
	input  wire bmad_pkg::access_t acc,
	input  wire bmad_pkg::cfg_t    cfg,
	input  wire logic [7:0]        ram_sel,
	input  wire logic [7:0]        rom_sel,
	output bmad_pkg::result_t      res,
	output bmad_pkg::bank_wr_t     bank_wr
);
	import bmad_pkg::*;

	localparam logic [8:0] ROM_BANKS = 9'(BUILTIN_ROM_BANKS);

	logic        is_write;
	logic        is_peek;
	logic [7:0]  cbank;
	logic [15:0] addr;
	logic [7:0]  hi;
	logic [7:0]  win_bank_ram;
	logic [7:0]  win_bank_rom;
	logic        use_ovr;
	logic [16:0] uart1_end;
	logic [16:0] uart2_end;
	logic        uart1_hit;
	logic        uart2_hit;
	logic        reaches;

	assign addr     = acc.address;
	assign hi       = addr[15:8];
	assign is_write = (acc.action == ACT_WRITE);
	assign is_peek  = acc.action[1];
	assign cbank    = cfg.gen2_mode ? acc.cpu_bank : 8'd0;

	// Window bank: peeks may name their own bank
	assign use_ovr      = is_peek && !acc.bank_override[8];
	assign win_bank_ram = use_ovr ? acc.bank_override[7:0] : ram_sel;
	assign win_bank_rom = use_ovr ? acc.bank_override[7:0] : rom_sel;

	// UART windows, eight registers each
	assign uart1_end = {1'b0, cfg.uart1_base} + 17'd7;
	assign uart2_end = {1'b0, cfg.uart2_base} + 17'd7;
	assign uart1_hit = cfg.device_enables[DEV_UART1] && (addr >= cfg.uart1_base)
		&& ({1'b0, addr} <= uart1_end);
	assign uart2_hit = cfg.device_enables[DEV_UART2] && (addr >= cfg.uart2_base)
		&& ({1'b0, addr} <= uart2_end);

	// Address decode
	always_comb begin
		res.target           = TGT_NONE;
		res.physical_address = 24'd0;
		res.register_offset  = 5'd0;
		res.open_bus_data    = 8'd0;
		res.wait_cycles      = 2'd0;
		reaches              = 1'b0;
		bank_wr.ram_we       = 1'b0;
		bank_wr.rom_we       = 1'b0;
		bank_wr.data         = acc.write_data;

		priority if (cbank != 8'd0) begin
			// extended system RAM bank
			if ({1'b0, cbank} < cfg.system_bank_count) begin
				res.target           = TGT_SYSRAM;
				res.physical_address = {cbank, addr};
				reaches              = 1'b1;
			end else begin
				res.open_bus_data = hi;
			end
		end else if (addr < ADDR_IO_BASE) begin
			// low RAM; addresses 0 and 1 also load the bank registers
			bank_wr.ram_we       = is_write && (addr[15:1] == 15'd0) && !addr[0];
			bank_wr.rom_we       = is_write && (addr[15:1] == 15'd0) && addr[0];
			res.target           = TGT_SYSRAM;
			res.physical_address = {8'd0, addr};
			reaches              = 1'b1;
		end else if (addr < ADDR_BRAM_BASE) begin
			// I/O page, fixed priority
			if (!is_peek && addr >= ADDR_SLOW_BASE)
				res.wait_cycles = SLOW_WAITS;
			priority if (addr < ADDR_VIA2_BASE) begin
				res.target          = TGT_VIA1;
				res.register_offset = {1'b0, addr[3:0]};
			end else if (cfg.device_enables[DEV_VIA2] && addr < ADDR_VIDEO_BASE) begin
				res.target          = TGT_VIA2;
				res.register_offset = {1'b0, addr[3:0]};
			end else if (addr >= ADDR_VIDEO_BASE && addr < ADDR_SOUND_BASE) begin
				res.target          = TGT_VIDEO;
				res.register_offset = addr[4:0];
			end else if (addr >= ADDR_SOUND_BASE && addr < ADDR_SOUND_END) begin
				if (!is_peek)
					res.wait_cycles = SLOW_WAITS;
				if (is_write || addr[0]) begin
					res.target          = TGT_SOUND;
					res.register_offset = {4'd0, addr[0]};
				end else begin
					res.open_bus_data = IO_OPEN_BUS;
				end
			end else if (addr >= ADDR_EMU_BASE && addr < ADDR_EMU_END) begin
				res.target          = TGT_EMU;
				res.register_offset = {1'b0, addr[3:0]};
			end else if (cfg.device_enables[DEV_MIDI]
					&& (addr & MIDI_MASK) == cfg.midi_base) begin
				res.target          = TGT_MIDI;
				res.register_offset = {1'b0, addr[3:0]};
			end else if (uart1_hit) begin
				res.target          = TGT_UART1;
				res.register_offset = {2'd0, addr[2:0]};
			end else if (uart2_hit) begin
				res.target          = TGT_UART2;
				res.register_offset = {2'd0, addr[2:0]};
			end else begin
				res.open_bus_data = IO_OPEN_BUS;
			end
			reaches = (res.target != TGT_NONE);
		end else if (addr < ADDR_ROM_BASE) begin
			// banked RAM window, 8K pages
			if ({1'b0, win_bank_ram} < cfg.banked_ram_count) begin
				res.target           = TGT_BANKRAM;
				res.physical_address = {3'd0, win_bank_ram, addr[12:0]};
				reaches              = 1'b1;
			end else begin
				res.open_bus_data = hi;
			end
		end else begin
			// ROM / cartridge window, 16K banks; ROM ignores writes
			if ({1'b0, win_bank_rom} < ROM_BANKS) begin
				res.target           = TGT_ROM;
				res.physical_address = {2'd0, win_bank_rom, addr[13:0]};
			end else if (cfg.device_enables[DEV_CART]) begin
				res.target           = TGT_CART;
				res.physical_address = {2'd0, win_bank_rom, addr[13:0]};
				reaches              = 1'b1;
			end else begin
				res.open_bus_data = hi;
			end
		end

		res.write_strobe = is_write && reaches;
	end

endmodule

`default_nettype wire

// ===== rtl/banked_memory_address_decoder.sv =====
// Bus access decoder for a banked 8-bit machine. Each request on the slave
// stream is one CPU access (read, write or debug peek); the master stream
// returns one result per request: target select, physical address, device
// register offset, open-bus byte, wait cycles and write strobe. Requests are
// taken every cycle unless the output backs up; each passes the input
// register, then the result register, which lets a new request in while a
// result waits for tready. Bank 0 writes to addresses 0 and 1 load the RAM
// and ROM bank registers as the request leaves the input register, so the
// next request sees the new bank. The user writes configuration through the
// cfg port only while no request is in flight; the block does not check it.
`timescale 1ns / 1ps
`default_nettype none

module banked_memory_address_decoder #(
	parameter int BUILTIN_ROM_BANKS = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// tdata: address[15:0], cpu_bank[23:16], write_data[31:24],
	//        bank_override[40:32] (signed), zeros[47:41]
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [bmad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// tuser: action[1:0]
	input  wire logic [1:0]                      s_axis_tuser,
	// tdata: target[3:0], physical_address[27:4], register_offset[32:28],
	//        open_bus_data[40:33], wait_cycles[42:41], write_strobe[43],
	//        zeros[47:44]
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [bmad_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	input  wire logic                            cfg_we,
	input  wire logic [2:0]                      cfg_index,
	input  wire logic [bmad_pkg::CFG_DATA_W-1:0] cfg_data
);
	import bmad_pkg::*;

	cfg_t     cfg;
	access_t  acc_s1;
	logic     valid_s1;
	result_t  res_s2;
	logic     valid_s2;
	result_t  dec_res;
	bank_wr_t bank_wr;
	logic [7:0] ram_page_q;
	logic [7:0] rom_page_q;
	logic     accept_in;
	logic     fire_s1;

	// Configuration registers
	bmad_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index_t'(cfg_index)),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake
	assign fire_s1       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || fire_s1;
	assign accept_in     = s_axis_tvalid && s_axis_tready;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (fire_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			acc_s1.action        <= action_t'(s_axis_tuser);
			acc_s1.address       <= s_axis_tdata[15:0];
			acc_s1.cpu_bank      <= s_axis_tdata[23:16];
			acc_s1.write_data    <= s_axis_tdata[31:24];
			acc_s1.bank_override <= s_axis_tdata[40:32];
		end
	end

	// Decode
	bmad_decode #(
		.BUILTIN_ROM_BANKS (BUILTIN_ROM_BANKS)
	) u_decode (
		.acc      (acc_s1),
		.cfg      (cfg),
		.ram_sel  (ram_page_q),
		.rom_sel  (rom_page_q),
		.res      (dec_res),
		.bank_wr  (bank_wr)
	);

	// Bank registers, updated as the request moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ram_page_q <= 8'd0;
			rom_page_q <= 8'd0;
		end else if (fire_s1) begin
			if (bank_wr.ram_we)
				ram_page_q <= bank_wr.data;
			if (bank_wr.rom_we)
				rom_page_q <= bank_wr.data;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (fire_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1)
			res_s2 <= dec_res;
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {4'd0, res_s2.write_strobe, res_s2.wait_cycles,
		res_s2.open_bus_data, res_s2.register_offset, res_s2.physical_address,
		4'(res_s2.target)};

	// Checks
	a_bank_update_on_fire: assert property (@(posedge clk) disable iff (!arst_n)
		(!$stable(ram_page_q) || !$stable(rom_page_q)) |-> $past(fire_s1))
		else $error("bank register changed without a request leaving stage 1");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && valid_s2 && !m_axis_tready))
		else $error("input stalled while the pipeline has room");

	a_none_is_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.target == TGT_NONE) |->
		(res_s2.physical_address == 24'd0 && res_s2.register_offset == 5'd0
		&& !res_s2.write_strobe))
		else $error("open-bus result carries address, offset or strobe");

	a_rom_no_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.target == TGT_ROM) |-> !res_s2.write_strobe)
		else $error("write strobe raised for ROM");

	a_waits_io_only: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.wait_cycles != 2'd0) |->
		(res_s2.physical_address == 24'd0))
		else $error("wait cycles on a memory target");

endmodule

`default_nettype wire

// ===== tb/tb_banked_memory_address_decoder.sv =====
`timescale 1ns / 1ps

module tb_banked_memory_address_decoder;
	import bmad_pkg::*;

	localparam int ROM_BANKS    = 32;
	localparam int LIMIT_CYCLES = 250000;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_ITEMS  = 250;
	localparam int MAX_REPORTS  = 30;

	// One directed stimulus row; res is only meaningful when pinned is set
	typedef struct {
		access_t acc;
		bit      pinned;
		result_t res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	access_t cur_access = '0;
	logic m_tready = 1'b0;
	logic cfg_we = 1'b0;
	cfg_index_t cfg_idx = CFG_GEN2_MODE;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	wire logic s_axis_tready;
	wire logic m_axis_tvalid;
	wire logic [OUT_DATA_W-1:0] m_tdata;
	wire logic [IN_DATA_W-1:0] s_tdata;

	// tdata: address, cpu_bank, write_data, bank_override, zero fill
	assign s_tdata = {7'b0, cur_access.bank_override, cur_access.write_data,
		cur_access.cpu_bank, cur_access.address};

	// Shadow of the block's configuration and bank registers
	cfg_t model_cfg;
	logic [7:0] model_ram_page;
	logic [7:0] model_rom_page;

	result_t pending_results[$];
	stim_row_t directed_expect[$];
	stim_row_t directed_rows[$];

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_asked = 0;
	int hold_given = 0;
	int hold_left = 0;
	int errors = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int settings_applied = 0;
	int cycles = 0;
	logic [15:0] targets_seen = '0;

	banked_memory_address_decoder #(
		.BUILTIN_ROM_BANKS(ROM_BANKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_tdata),
		.s_axis_tuser(cur_access.action),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_tready),
		.m_axis_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_idx),
		.cfg_data(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Decode one access against the shadow state; bank writes update it
	function automatic result_t decode_access(input access_t a);
		result_t r;
		logic peek;
		logic wr;
		logic reaches;
		logic [7:0] xbank;
		logic [8:0] win;
		r = '0;
		r.target = TGT_NONE;
		reaches = 1'b0;
		peek = (a.action == ACT_PEEK) || (a.action == ACT_PEEK3);
		wr = a.action == ACT_WRITE;
		xbank = model_cfg.gen2_mode ? a.cpu_bank : 8'd0;
		if (xbank != 8'd0) begin
			// extended bank: system RAM or nothing, bank registers untouched
			if ({1'b0, xbank} < model_cfg.system_bank_count) begin
				r.target = TGT_SYSRAM;
				r.physical_address = {xbank, a.address};
				reaches = 1'b1;
			end else begin
				r.open_bus_data = a.address[15:8];
			end
		end else if (a.address < ADDR_IO_BASE) begin
			if (wr && a.address == 16'd0)
				model_ram_page = a.write_data;
			else if (wr && a.address == 16'd1)
				model_rom_page = a.write_data;
			r.target = TGT_SYSRAM;
			r.physical_address = {8'd0, a.address};
			reaches = 1'b1;
		end else if (a.address < ADDR_BRAM_BASE) begin
			// I/O page, devices in fixed priority
			if (!peek && a.address >= ADDR_SLOW_BASE)
				r.wait_cycles = SLOW_WAITS;
			if (a.address < ADDR_VIA2_BASE) begin
				r.target = TGT_VIA1;
				r.register_offset = {1'b0, a.address[3:0]};
			end else if (model_cfg.device_enables[DEV_VIA2]
					&& a.address < ADDR_VIDEO_BASE) begin
				r.target = TGT_VIA2;
				r.register_offset = {1'b0, a.address[3:0]};
			end else if (a.address >= ADDR_VIDEO_BASE
					&& a.address < ADDR_SOUND_BASE) begin
				r.target = TGT_VIDEO;
				r.register_offset = a.address[4:0];
			end else if (a.address >= ADDR_SOUND_BASE
					&& a.address < ADDR_SOUND_END) begin
				if (!peek)
					r.wait_cycles = SLOW_WAITS;
				if (wr || a.address[0]) begin
					r.target = TGT_SOUND;
					r.register_offset = {4'd0, a.address[0]};
				end else begin
					r.open_bus_data = IO_OPEN_BUS;
				end
			end else if (a.address >= ADDR_EMU_BASE && a.address < ADDR_EMU_END) begin
				r.target = TGT_EMU;
				r.register_offset = {1'b0, a.address[3:0]};
			end else if (model_cfg.device_enables[DEV_MIDI]
					&& (a.address & MIDI_MASK) == model_cfg.midi_base) begin
				r.target = TGT_MIDI;
				r.register_offset = {1'b0, a.address[3:0]};
			end else if (model_cfg.device_enables[DEV_UART1]
					&& a.address >= model_cfg.uart1_base
					&& {1'b0, a.address} <= {1'b0, model_cfg.uart1_base} + 17'd7) begin
				r.target = TGT_UART1;
				r.register_offset = {2'd0, a.address[2:0]};
			end else if (model_cfg.device_enables[DEV_UART2]
					&& a.address >= model_cfg.uart2_base
					&& {1'b0, a.address} <= {1'b0, model_cfg.uart2_base} + 17'd7) begin
				r.target = TGT_UART2;
				r.register_offset = {2'd0, a.address[2:0]};
			end else begin
				r.open_bus_data = IO_OPEN_BUS;
			end
			reaches = r.target != TGT_NONE;
		end else if (a.address < ADDR_ROM_BASE) begin
			// banked RAM window; a peek may name its own page
			win = (peek && !a.bank_override[8]) ? {1'b0, a.bank_override[7:0]}
				: {1'b0, model_ram_page};
			if (win < model_cfg.banked_ram_count) begin
				r.target = TGT_BANKRAM;
				r.physical_address = {3'd0, win[7:0], a.address[12:0]};
				reaches = 1'b1;
			end else begin
				r.open_bus_data = a.address[15:8];
			end
		end else begin
			// ROM window, cartridge above the built-in banks
			win = (peek && !a.bank_override[8]) ? {1'b0, a.bank_override[7:0]}
				: {1'b0, model_rom_page};
			if (win < ROM_BANKS) begin
				r.target = TGT_ROM;
				r.physical_address = {2'd0, win[7:0], a.address[13:0]};
			end else if (model_cfg.device_enables[DEV_CART]) begin
				r.target = TGT_CART;
				r.physical_address = {2'd0, win[7:0], a.address[13:0]};
				reaches = 1'b1;
			end else begin
				r.open_bus_data = a.address[15:8];
			end
		end
		r.write_strobe = wr && reaches;
		return r;
	endfunction

	// Work out the expected result for every request taken by the block
	always @(posedge clk) begin : predict_requests
		result_t r;
		stim_row_t row;
		if (arst_n && s_tvalid && s_axis_tready === 1'b1) begin
			r = decode_access(cur_access);
			if (directed_expect.size() != 0) begin
				row = directed_expect.pop_front();
				if (row.pinned)
					r = row.res;
			end
			pending_results.push_back(r);
			requests_sent++;
		end
	end

	// Compare each delivered result with the oldest expectation
	always @(posedge clk) begin : check_results
		result_t got;
		result_t want;
		logic ok;
		if (arst_n && m_axis_tvalid === 1'b1 && m_tready) begin
			got.target = target_t'(m_tdata[3:0]);
			got.physical_address = m_tdata[27:4];
			got.register_offset = m_tdata[32:28];
			got.open_bus_data = m_tdata[40:33];
			got.wait_cycles = m_tdata[42:41];
			got.write_strobe = m_tdata[43];
			if (pending_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display({"%0t: result with none outstanding: ",
						"tgt %0d pa %h ro %h ob %h wc %0d ws %0d"},
						$time, got.target, got.physical_address, got.register_offset,
						got.open_bus_data, got.wait_cycles, got.write_strobe);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				targets_seen[got.target] = 1'b1;
				ok = (got.target === want.target)
					&& (got.physical_address === want.physical_address)
					&& (got.register_offset === want.register_offset)
					&& (got.open_bus_data === want.open_bus_data)
					&& (got.wait_cycles === want.wait_cycles)
					&& (got.write_strobe === want.write_strobe);
				if (!ok) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display({"%0t: expected tgt %0d pa %h ro %h ob %h wc %0d ws %0d, ",
							"got tgt %0d pa %h ro %h ob %h wc %0d ws %0d"},
							$time, want.target, want.physical_address, want.register_offset,
							want.open_bus_data, want.wait_cycles, want.write_strobe,
							got.target, got.physical_address, got.register_offset,
							got.open_bus_data, got.wait_cycles, got.write_strobe);
				end
			end
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else if (hold_asked != hold_given) begin
			hold_given = hold_asked;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("%0t: run did not complete, %0d results outstanding", $time,
				pending_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	// Offer one request, with random gaps ahead of it, and wait until taken
	task automatic push_access(input access_t a);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		cur_access <= a;
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
	endtask

	// Stop sending and let every outstanding result come back; the first
	// edge lets the predictor record the request taken at the current one
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all registers of one setting back to back (block is idle)
	task automatic apply_settings(input cfg_t c);
		cfg_index_t idx;
		logic [CFG_DATA_W-1:0] val;
		for (int i = 0; i < 7; i++) begin
			idx = cfg_index_t'(i);
			case (idx)
				CFG_GEN2_MODE:   val = {15'd0, c.gen2_mode};
				CFG_SYS_BANKS:   val = {7'd0, c.system_bank_count};
				CFG_BRAM_COUNT:  val = {7'd0, c.banked_ram_count};
				CFG_DEV_ENABLES: val = {11'd0, c.device_enables};
				CFG_MIDI_BASE:   val = c.midi_base;
				CFG_UART1_BASE:  val = c.uart1_base;
				CFG_UART2_BASE:  val = c.uart2_base;
				default:         val = '0;
			endcase
			cfg_we <= 1'b1;
			cfg_idx <= idx;
			cfg_wdata <= val;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		model_cfg = c;
		settings_applied++;
		@(posedge clk);
	endtask

	task automatic add_row(input action_t act, input logic [15:0] addr,
			input logic [7:0] cb, input logic [7:0] wd, input logic [8:0] ovr,
			input bit pin, input target_t tgt, input logic [23:0] pa,
			input logic [4:0] ro, input logic [7:0] ob, input logic [1:0] wc,
			input logic ws);
		stim_row_t row;
		row.acc.action = act;
		row.acc.address = addr;
		row.acc.cpu_bank = cb;
		row.acc.write_data = wd;
		row.acc.bank_override = ovr;
		row.pinned = pin;
		row.res.target = tgt;
		row.res.physical_address = pa;
		row.res.register_offset = ro;
		row.res.open_bus_data = ob;
		row.res.wait_cycles = wc;
		row.res.write_strobe = ws;
		directed_rows.push_back(row);
	endtask

	// Random accesses, mostly aimed at the bank registers and the windows
	task automatic run_phase(input int n);
		access_t a;
		int sel;
		int pick;
		for (int k = 0; k < n; k++) begin
			sel = $urandom_range(99);
			pick = $urandom_range(9);
			if (pick < 4)
				a.action = ACT_READ;
			else if (pick < 7)
				a.action = ACT_WRITE;
			else if (pick < 9)
				a.action = ACT_PEEK;
			else
				a.action = ACT_PEEK3;
			if ($urandom_range(99) < 70)
				a.cpu_bank = 8'd0;
			else if ($urandom_range(1) != 0)
				a.cpu_bank = 8'($urandom_range(1, 5));
			else
				a.cpu_bank = 8'($urandom_range(255));
			if (sel < 12)
				a.address = 16'($urandom_range(1));
			else if (sel < 40)
				a.address = ADDR_IO_BASE + 16'($urandom_range(255));
			else if (sel < 60)
				a.address = ADDR_BRAM_BASE + 16'($urandom_range(16'h1FFF));
			else if (sel < 80)
				a.address = ADDR_ROM_BASE + 16'($urandom_range(16'h3FFF));
			else
				a.address = 16'($urandom_range(16'hFFFF));
			a.write_data = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
				: 8'($urandom_range(70));
			case ($urandom_range(3))
				0: a.bank_override = 9'h1FF;
				1: a.bank_override = 9'($urandom_range(511));
				default: a.bank_override = 9'($urandom_range(70));
			endcase
			push_access(a);
			// receiver holds off while requests keep coming
			if (k == n / 3)
				hold_asked++;
			// sender waits for every outstanding result
			if (k == n / 2)
				drain();
		end
		drain();
	endtask

	initial begin : stimulus
		cfg_t c;
		stim_row_t row;
		model_cfg.gen2_mode = 1'b0;
		model_cfg.system_bank_count = RST_SYS_BANKS;
		model_cfg.banked_ram_count = RST_BRAM_COUNT;
		model_cfg.device_enables = '0;
		model_cfg.midi_base = RST_MIDI_BASE;
		model_cfg.uart1_base = RST_UART1_BASE;
		model_cfg.uart2_base = RST_UART2_BASE;
		model_ram_page = '0;
		model_rom_page = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset configuration, no idling
		run_phase(100);

		// Directed accesses with every device enabled and extended banks on
		c = '{gen2_mode: 1'b1, system_bank_count: 9'd4, banked_ram_count: 9'd64,
			device_enables: 5'h1F, midi_base: 16'h9F60, uart1_base: 16'h9FC0,
			uart2_base: 16'h9FC8};
		apply_settings(c);
		// bank register loads at low RAM addresses 0 and 1
		add_row(ACT_READ,  16'h0000, 8'h00, 8'h00, 9'h1FF,
			1, TGT_SYSRAM, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_WRITE, 16'h0000, 8'h00, 8'h05, 9'h1FF,
			1, TGT_SYSRAM, 24'h0, 5'h0, 8'h00, 2'd0, 1);
		add_row(ACT_WRITE, 16'h0001, 8'h00, 8'h21, 9'h1FF,
			1, TGT_SYSRAM, 24'h1, 5'h0, 8'h00, 2'd0, 1);
		// windows with the new banks, cartridge above the built-in ROM
		add_row(ACT_READ,  16'hA000, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'hFFFF, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_WRITE, 16'hC000, 8'h00, 8'hFF, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		// peeks: current bank, page out of range, explicit ROM bank
		add_row(ACT_PEEK,  16'hBFFF, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_PEEK,  16'hBFFF, 8'h00, 8'h00, 9'h0FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'hBF, 2'd0, 0);
		add_row(ACT_PEEK,  16'hC000, 8'h00, 8'h00, 9'h000,
			1, TGT_ROM, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_WRITE, 16'h0000, 8'h00, 8'h00, 9'h1FF,
			1, TGT_SYSRAM, 24'h0, 5'h0, 8'h00, 2'd0, 1);
		add_row(ACT_WRITE, 16'h0001, 8'h00, 8'h03, 9'h1FF,
			1, TGT_SYSRAM, 24'h1, 5'h0, 8'h00, 2'd0, 1);
		// write to ROM is dropped
		add_row(ACT_WRITE, 16'hD000, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		// I/O page devices, sound range and unclaimed slots
		add_row(ACT_READ,  16'h9F00, 8'h00, 8'h00, 9'h1FF,
			1, TGT_VIA1, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'h9F1F, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'h9F3F, 8'h00, 8'h00, 9'h1FF,
			1, TGT_VIDEO, 24'h0, 5'h1F, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'h9F40, 8'h00, 8'h00, 9'h1FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'h9F, 2'd3, 0);
		add_row(ACT_READ,  16'h9F41, 8'h00, 8'h00, 9'h1FF,
			1, TGT_SOUND, 24'h0, 5'h1, 8'h00, 2'd3, 0);
		add_row(ACT_WRITE, 16'h9F42, 8'h00, 8'hFF, 9'h1FF,
			1, TGT_SOUND, 24'h0, 5'h0, 8'h00, 2'd3, 1);
		add_row(ACT_PEEK,  16'h9F40, 8'h00, 8'h00, 9'h1FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'h9F, 2'd0, 0);
		add_row(ACT_READ,  16'h9F60, 8'h00, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'h9FA0, 8'h00, 8'h00, 9'h1FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'h9F, 2'd3, 0);
		add_row(ACT_READ,  16'h9FBF, 8'h00, 8'h00, 9'h1FF,
			1, TGT_EMU, 24'h0, 5'hF, 8'h00, 2'd3, 0);
		add_row(ACT_WRITE, 16'h9FCF, 8'h00, 8'hFF, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		// the spare action code decodes as a peek
		add_row(ACT_PEEK3, 16'h9FFF, 8'h00, 8'h00, 9'h1FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'h9F, 2'd0, 0);
		// extended banks: present, then missing with a bank register address
		add_row(ACT_READ,  16'h1234, 8'h03, 8'h00, 9'h1FF,
			0, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_WRITE, 16'h0000, 8'hFF, 8'hAA, 9'h1FF,
			1, TGT_NONE, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		add_row(ACT_READ,  16'hA000, 8'h00, 8'h00, 9'h1FF,
			1, TGT_BANKRAM, 24'h0, 5'h0, 8'h00, 2'd0, 0);
		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			directed_expect.push_back(row);
			push_access(row.acc);
		end
		drain();

		// Random phases under several settings and idling patterns
		for (int p = 0; p < 7; p++) begin
			case (p)
				0: c = '{gen2_mode: 1'b0, system_bank_count: RST_SYS_BANKS,
					banked_ram_count: RST_BRAM_COUNT, device_enables: 5'h00,
					midi_base: RST_MIDI_BASE, uart1_base: RST_UART1_BASE,
					uart2_base: RST_UART2_BASE};
				1: c = '{gen2_mode: 1'b1, system_bank_count: 9'd256, banked_ram_count: 9'd256,
					device_enables: 5'h1F, midi_base: 16'h9FF0, uart1_base: 16'h9FF8,
					uart2_base: 16'h9FF8};
				2: c = '{gen2_mode: 1'b1, system_bank_count: 9'd1, banked_ram_count: 9'd0,
					device_enables: 5'h1F, midi_base: 16'h9F00, uart1_base: 16'h9F00,
					uart2_base: 16'h9F00};
				default: begin
					c.gen2_mode = 1'($urandom_range(1));
					c.system_bank_count = 9'($urandom_range(1, 256));
					c.banked_ram_count = 9'($urandom_range(256));
					c.device_enables = 5'($urandom_range(31));
					c.midi_base = 16'h9F00 + 16'($urandom_range(15) * 16);
					c.uart1_base = 16'h9F00 + 16'($urandom_range(248));
					c.uart2_base = 16'h9F00 + 16'($urandom_range(248));
				end
			endcase
			apply_settings(c);
			case (p % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			run_phase(PHASE_ITEMS);
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();
		$display("Run: %0d requests over %0d register settings, %0d results checked",
			requests_sent, settings_applied, results_checked);
		$display("Targets seen %b", targets_seen[12:0]);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bmad_pkg.sv
rtl/bmad_cfg_regs.sv
rtl/bmad_decode.sv
rtl/banked_memory_address_decoder.sv
tb/tb_banked_memory_address_decoder.sv
